FILE: hw/rtl/three_word_shift_xor_rng_assert.svh
// Assertion macros shared by the checker of the shift-xor generator.
`ifndef THREE_WORD_SHIFT_XOR_RNG_ASSERT_SVH
`define THREE_WORD_SHIFT_XOR_RNG_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define TSXR_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shift-xor generator check failed");

// Clocked assertion that is also checked during reset.
`define TSXR_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("shift-xor generator reset check failed");

`endif

FILE: hw/rtl/tsxr_pkg.sv
// Package: widths, request codes, controller types and generator functions.
`timescale 1ns / 1ps
package tsxr_pkg;

    localparam int unsigned WORD_W   = 16;
    localparam int unsigned SEED_W   = 31;
    localparam int unsigned SCALE_W  = 17;
    localparam int unsigned THR_W    = 8;
    localparam int unsigned REQ_W    = 3;
    localparam int unsigned ROLL_W   = 7;
    localparam int unsigned M7_W     = 3;
    localparam int unsigned M23_W    = 5;
    localparam int unsigned CNT_W    = 5;
    localparam int unsigned PROD_W   = WORD_W + SCALE_W;
    localparam int unsigned MOD_A    = 7;
    localparam int unsigned MOD_B    = 23;
    localparam int unsigned ROLL_SPAN = 100;

    // Residue pipeline: 2^11 is one more than a multiple of 23, so 11-bit chunks fold.
    localparam int unsigned CH23_W     = 11;
    localparam int unsigned F7_W       = 7;
    localparam int unsigned G7_W       = 4;
    localparam int unsigned F23_W      = 13;
    localparam int unsigned G23_W      = 12;
    localparam int unsigned Q23_W      = 7;
    localparam int unsigned QPROD_W    = 24;
    localparam int unsigned RECIP_23   = 2850;
    localparam int unsigned RECIP_SH   = 16;
    localparam int unsigned RES_CYCLES = 4;

    typedef logic [REQ_W-1:0] t_req;

    // Request codes.
    localparam t_req REQ_RESEED = 3'd0;
    localparam t_req REQ_LOAD   = 3'd1;
    localparam t_req REQ_DRAW   = 3'd2;
    localparam t_req REQ_ROLL   = 3'd3;
    localparam t_req REQ_ROLL2  = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESIDUE,
        ST_SEED,
        ST_WARMUP,
        ST_STEP1,
        ST_STEP2,
        ST_MUL,
        ST_FINISH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic load_words;
        logic res_shift;
        logic seed_words;
        logic gen_step;
        logic warm_dec;
        logic mul_first;
        logic mul_second;
        logic out_load;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        t_req in_req;
        t_req req;
        logic warm_zero;
        logic out_free;
    } t_stat;

    // Table of starting words for a reseed.
    function automatic logic [WORD_W-1:0] seed_word(input logic [M7_W-1:0] idx);
        logic [WORD_W-1:0] w;
        unique case (idx)
            3'd0: w = 16'hA36E;
            3'd1: w = 16'h924E;
            3'd2: w = 16'hB784;
            3'd3: w = 16'h4F67;
            3'd4: w = 16'h8092;
            3'd5: w = 16'h592D;
            3'd6: w = 16'h8E70;
            3'd7: w = 16'hA794;
        endcase
        return w;
    endfunction

    // One generator step: ((w1 << 11) + (w0 >> 5)) xor (w2 << 1 | w1 top bit).
    function automatic logic [WORD_W-1:0] gen_next(
        input logic [WORD_W-1:0] w0,
        input logic [WORD_W-1:0] w1,
        input logic [WORD_W-1:0] w2
    );
        logic [WORD_W-1:0] t;
        logic [WORD_W-1:0] s;
        t = {w1[4:0], 11'b0} + {5'b0, w0[15:5]};
        s = {w2[14:0], w1[15]};
        return t ^ s;
    endfunction

endpackage

FILE: hw/rtl/tsxr_ifs.sv
// Request and response channel interfaces of the shift-xor generator.
`timescale 1ns / 1ps
interface tsxr_req_if import tsxr_pkg::*; ();
    logic               valid;
    logic               ready;
    t_req               req_type;
    logic [SEED_W-1:0]  seed;
    logic [SCALE_W-1:0] range_max;
    logic [THR_W-1:0]   threshold;
    logic [WORD_W-1:0]  load_word0;
    logic [WORD_W-1:0]  load_word1;
    logic [WORD_W-1:0]  load_word2;

    modport source (output valid, req_type, seed, range_max, threshold,
                    load_word0, load_word1, load_word2, input ready);
    modport sink   (input valid, req_type, seed, range_max, threshold,
                    load_word0, load_word1, load_word2, output ready);
endinterface

interface tsxr_rsp_if import tsxr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] value;
    logic              hit;
    logic [WORD_W-1:0] state_word0;
    logic [WORD_W-1:0] state_word1;
    logic [WORD_W-1:0] state_word2;

    modport source (output valid, value, hit, state_word0, state_word1, state_word2,
                    input ready);
    modport sink   (input valid, value, hit, state_word0, state_word1, state_word2,
                    output ready);
endinterface

FILE: hw/rtl/tsxr_datapath.sv
// Datapath: state words, seed residues, multiplier and output register.
`timescale 1ns / 1ps
module tsxr_datapath import tsxr_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cmd           i_cmd,
    output t_stat          o_stat,
    tsxr_req_if.sink       i_req,
    tsxr_rsp_if.source     o_rsp
);

    logic [WORD_W-1:0]  r_w0, r_w1, r_w2;
    logic [M23_W-1:0]   r_warm;
    logic               r_out_valid;

    t_req               r_req;
    logic [SEED_W-1:0]  r_seed;
    logic [SCALE_W-1:0] r_scale;
    logic [THR_W-1:0]   r_thr;
    logic [F7_W-1:0]    r_f7;
    logic [F23_W-1:0]   r_f23;
    logic [G7_W-1:0]    r_g7;
    logic [G23_W-1:0]   r_g23;
    logic [G23_W-1:0]   r_h23;
    logic [Q23_W-1:0]   r_q23;
    logic [M7_W-1:0]    r_m7;
    logic [M23_W-1:0]   r_m23;
    logic [WORD_W-1:0]  r_va;
    logic [ROLL_W-1:0]  r_vb;
    logic [WORD_W-1:0]  r_out_value;
    logic               r_out_hit;
    logic [WORD_W-1:0]  r_out_w0, r_out_w1, r_out_w2;

    logic [WORD_W-1:0]  w_rn;
    logic [F7_W-1:0]    w_f7;
    logic [F23_W-1:0]   w_f23;
    logic [G7_W-1:0]    w_g7;
    logic [G23_W-1:0]   w_g23;
    logic [QPROD_W-1:0] w_qprod;
    logic [Q23_W-1:0]   w_q23;
    logic [M7_W-1:0]    w_m7;
    logic [M23_W-1:0]   w_m23;
    logic [SCALE_W-1:0] w_mult;
    logic [PROD_W-1:0]  w_prod;
    logic [WORD_W-1:0]  w_sat;
    logic [ROLL_W:0]    w_sum;
    logic [WORD_W-1:0]  w_value;
    logic               w_hit;

    // Next generator number from the current words.
    assign w_rn = gen_next(r_w0, r_w1, r_w2);

    // Seed residues through a register pipeline. Eight leaves one against 7 and 2^11 leaves
    // one against 23, so chunk sums fold the seed down; a reciprocal multiply then
    // finds the quotient by 23 and a subtraction leaves the remainder.
    always_comb begin
        w_f7 = '0;
        for (int k = 0; k < SEED_W / M7_W; k++) begin
            w_f7 = w_f7 + F7_W'(r_seed[M7_W*k +: M7_W]);
        end
        w_f7 = w_f7 + F7_W'(r_seed[SEED_W-1]);
    end

    assign w_f23 = F23_W'(r_seed[CH23_W-1:0]) + F23_W'(r_seed[2*CH23_W-1:CH23_W])
                 + F23_W'(r_seed[SEED_W-1:2*CH23_W]);

    assign w_g7  = G7_W'(r_f7[M7_W-1:0]) + G7_W'(r_f7[2*M7_W-1:M7_W])
                 + G7_W'(r_f7[F7_W-1]);
    assign w_g23 = G23_W'(r_f23[CH23_W-1:0]) + G23_W'(r_f23[F23_W-1:CH23_W]);

    assign w_m7  = (r_g7 >= G7_W'(2*MOD_A)) ? M7_W'(r_g7 - G7_W'(2*MOD_A))
                 : (r_g7 >= G7_W'(MOD_A))   ? M7_W'(r_g7 - G7_W'(MOD_A))
                                            : r_g7[M7_W-1:0];
    assign w_qprod = QPROD_W'(r_g23) * QPROD_W'(RECIP_23);
    assign w_q23   = w_qprod[RECIP_SH +: Q23_W];
    assign w_m23   = M23_W'(r_h23 - G23_W'(r_q23) * G23_W'(MOD_B));

    // Shared multiplier: scale for a draw, the roll span otherwise.
    assign w_mult = (r_req == REQ_DRAW) ? r_scale : SCALE_W'(ROLL_SPAN);
    assign w_prod = PROD_W'(r_w0) * PROD_W'(w_mult);
    assign w_sat  = w_prod[PROD_W-1] ? {WORD_W{1'b1}} : w_prod[2*WORD_W-1:WORD_W];

    // Result value and hit flag per request type.
    assign w_sum = {1'b0, r_va[ROLL_W-1:0]} + {1'b0, r_vb};

    always_comb begin
        w_value = '0;
        w_hit   = 1'b0;
        unique case (r_req)
            REQ_DRAW: begin
                w_value = r_va;
            end
            REQ_ROLL: begin
                w_value = r_va;
                w_hit   = (WORD_W'(r_thr) > r_va);
            end
            REQ_ROLL2: begin
                w_value = WORD_W'(w_sum[ROLL_W:1]);
                w_hit   = (WORD_W'(r_thr) > WORD_W'(w_sum[ROLL_W:1]));
            end
            default: begin
                w_value = '0;
                w_hit   = 1'b0;
            end
        endcase
    end

    // State words, warm-up count and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_w0        <= '0;
            r_w1        <= '0;
            r_w2        <= '0;
            r_warm      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.load_words) begin
                r_w0 <= i_req.load_word0;
                r_w1 <= i_req.load_word1;
                r_w2 <= i_req.load_word2;
            end else if (i_cmd.seed_words) begin
                r_w0 <= seed_word(r_m7);
                r_w1 <= seed_word(r_m7 + 3'd1);
                r_w2 <= seed_word(r_m7 + 3'd2);
            end else if (i_cmd.gen_step) begin
                r_w0 <= w_rn;
                r_w1 <= r_w0;
                r_w2 <= r_w1;
            end
            if (i_cmd.seed_words) begin
                r_warm <= r_m23;
            end else if (i_cmd.warm_dec) begin
                r_warm <= r_warm - 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Captured request fields, residues, roll values and output payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req   <= i_req.req_type;
            r_seed  <= i_req.seed;
            r_scale <= i_req.range_max;
            r_thr   <= i_req.threshold;
        end else if (i_cmd.res_shift) begin
            r_f7    <= w_f7;
            r_f23   <= w_f23;
            r_g7    <= w_g7;
            r_g23   <= w_g23;
            r_h23   <= r_g23;
            r_q23   <= w_q23;
            r_m7    <= w_m7;
            r_m23   <= w_m23;
        end
        if (i_cmd.mul_first) begin
            r_va <= w_sat;
        end
        if (i_cmd.mul_second) begin
            r_vb <= w_prod[WORD_W+ROLL_W-1:WORD_W];
        end
        if (i_cmd.out_load) begin
            r_out_value <= w_value;
            r_out_hit   <= w_hit;
            r_out_w0    <= r_w0;
            r_out_w1    <= r_w1;
            r_out_w2    <= r_w2;
        end
    end

    assign o_stat.in_req    = i_req.req_type;
    assign o_stat.req       = r_req;
    assign o_stat.warm_zero = (r_warm == '0);
    assign o_stat.out_free  = !r_out_valid || o_rsp.ready;

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.value       = r_out_value;
    assign o_rsp.hit         = r_out_hit;
    assign o_rsp.state_word0 = r_out_w0;
    assign o_rsp.state_word1 = r_out_w1;
    assign o_rsp.state_word2 = r_out_w2;

endmodule

FILE: hw/rtl/tsxr_ctrl.sv
// Controller: sequences residue, warm-up, generator and multiply steps.
`timescale 1ns / 1ps
module tsxr_ctrl import tsxr_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_req_valid,
    output logic  o_req_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // State and residue cycle counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.capture    = 1'b1;
                    o_cmd.load_words = (i_stat.in_req == REQ_LOAD);
                    n_cnt            = '0;
                    unique case (i_stat.in_req)
                        REQ_RESEED: n_state = ST_RESIDUE;
                        REQ_DRAW:   n_state = ST_STEP1;
                        REQ_ROLL:   n_state = ST_STEP1;
                        REQ_ROLL2:  n_state = ST_STEP1;
                        default:    n_state = ST_FINISH;
                    endcase
                end
            end
            ST_RESIDUE: begin
                o_cmd.res_shift = 1'b1;
                n_cnt           = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(RES_CYCLES - 1)) begin
                    n_state = ST_SEED;
                end
            end
            ST_SEED: begin
                o_cmd.seed_words = 1'b1;
                n_state          = ST_WARMUP;
            end
            ST_WARMUP: begin
                if (i_stat.warm_zero) begin
                    n_state = ST_FINISH;
                end else begin
                    o_cmd.gen_step = 1'b1;
                    o_cmd.warm_dec = 1'b1;
                end
            end
            ST_STEP1: begin
                o_cmd.gen_step = 1'b1;
                n_state        = (i_stat.req == REQ_ROLL2) ? ST_STEP2 : ST_MUL;
            end
            ST_STEP2: begin
                // First roll is scaled while the second number is generated.
                o_cmd.gen_step  = 1'b1;
                o_cmd.mul_first = 1'b1;
                n_state         = ST_MUL;
            end
            ST_MUL: begin
                if (i_stat.req == REQ_ROLL2) begin
                    o_cmd.mul_second = 1'b1;
                end else begin
                    o_cmd.mul_first = 1'b1;
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hw/rtl/three_word_shift_xor_rng.sv
// From request beat to result valid: a load or unknown type goes straight to the output load,
// a draw or single roll generates and scales one number, a double roll two, and a reseed runs
// the residue steps, one word load, one warm-up step per cycle for seed mod 23 steps, one exit
// check and the output load. One request is served at a time and the next is taken once its
// result is registered. A finished result waits in the output register while the next is taken.
// Synchronous active-low reset clears the words to zero and empties the output.
`timescale 1ns / 1ps
module three_word_shift_xor_rng import tsxr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tsxr_req_if.sink   i_req,
    tsxr_rsp_if.source o_rsp
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  w_ready;

    assign i_req.ready = w_ready;

    // Sequencer.
    tsxr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (w_ready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Generator words and arithmetic.
    tsxr_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat),
        .i_req   (i_req),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: hw/rtl/tsxr_checker.sv
// Port checker of the shift-xor generator and its bind to the top level.
`timescale 1ns / 1ps
`include "three_word_shift_xor_rng_assert.svh"
module tsxr_checker import tsxr_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              i_req_ready,
    input logic              i_rsp_valid,
    input logic              i_rsp_ready,
    input logic [WORD_W-1:0] i_rsp_value,
    input logic              i_rsp_hit
);

    // A held result beat keeps its value and flag.
    `TSXR_ASSERT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_value) && $stable(i_rsp_hit))

    // Ready drops after every taken request, so no two requests are taken back to back.
    `TSXR_ASSERT(a_req_busy, i_clk, i_rst_n, i_req_valid && i_req_ready |=> !i_req_ready)

    // A hit only comes from a roll, whose value is below one hundred.
    `TSXR_ASSERT(a_hit_roll, i_clk, i_rst_n, i_rsp_valid && i_rsp_hit |-> i_rsp_value < 16'd100)

    // Reset empties the output register.
    `TSXR_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_rsp_valid)

endmodule

bind three_word_shift_xor_rng tsxr_checker u_tsxr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_value (o_rsp.value),
    .i_rsp_hit   (o_rsp.hit)
);

FILE: test/three_word_shift_xor_rng_test.sv
// Self-checking testbench for the three-word shift-xor generator.
`timescale 1ns / 1ps
module three_word_shift_xor_rng_test;
    import tsxr_pkg::*;

    // Request codes that the block does not define; they must leave the words alone.
    localparam t_req REQ_RSVD_A = 3'd5;
    localparam t_req REQ_RSVD_B = 3'd6;
    localparam t_req REQ_RSVD_C = 3'd7;

    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_PCT     = 28;
    localparam int DRAIN_CYCLES = 80;
    localparam int REPORT_LIMIT = 10;

    // Starting words that a reseed picks from.
    localparam logic [WORD_W-1:0] RESEED_WORDS [8] = '{
        16'hA36E, 16'h924E, 16'hB784, 16'h4F67,
        16'h8092, 16'h592D, 16'h8E70, 16'hA794
    };

    typedef struct packed {
        t_req               kind;
        logic [SEED_W-1:0]  seed;
        logic [SCALE_W-1:0] scale;
        logic [THR_W-1:0]   thr;
        logic [WORD_W-1:0]  w0;
        logic [WORD_W-1:0]  w1;
        logic [WORD_W-1:0]  w2;
    } t_req_beat;

    typedef struct packed {
        logic [WORD_W-1:0] value;
        logic              hit;
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
    } t_rsp_beat;

    typedef struct packed {
        t_req_beat beat;
        logic      typed;
        t_rsp_beat want;
    } t_table_row;

    logic clk;
    logic rst_n;
    logic idling_on;
    int   mismatches;

    logic [WORD_W-1:0] shadow_words [3];
    t_rsp_beat         pending_results [$];
    t_table_row        directed_rows [$];

    tsxr_req_if req_ch ();
    tsxr_rsp_if rsp_ch ();

    three_word_shift_xor_rng i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // Free-running clock.
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

    function automatic t_req_beat mk_req(input t_req kind, input logic [SEED_W-1:0] seed,
                                         input logic [SCALE_W-1:0] scale,
                                         input logic [THR_W-1:0] thr,
                                         input logic [WORD_W-1:0] w0,
                                         input logic [WORD_W-1:0] w1,
                                         input logic [WORD_W-1:0] w2);
        t_req_beat r;
        r.kind  = kind;
        r.seed  = seed;
        r.scale = scale;
        r.thr   = thr;
        r.w0    = w0;
        r.w1    = w1;
        r.w2    = w2;
        return r;
    endfunction

    function automatic t_rsp_beat mk_rsp(input logic [WORD_W-1:0] value, input logic hit,
                                         input logic [WORD_W-1:0] w0,
                                         input logic [WORD_W-1:0] w1,
                                         input logic [WORD_W-1:0] w2);
        t_rsp_beat r;
        r.value = value;
        r.hit   = hit;
        r.w0    = w0;
        r.w1    = w1;
        r.w2    = w2;
        return r;
    endfunction

    // One generator step on the shadow words; returns the new number.
    function automatic logic [WORD_W-1:0] advance_shadow();
        logic [WORD_W-1:0] mixed;
        logic [WORD_W-1:0] rotated;
        logic [WORD_W-1:0] rn;
        mixed   = (shadow_words[1] << 11) + (shadow_words[0] >> 5);
        rotated = (shadow_words[2] << 1) | (shadow_words[1] >> 15);
        rn      = mixed ^ rotated;
        shadow_words[2] = shadow_words[1];
        shadow_words[1] = shadow_words[0];
        shadow_words[0] = rn;
        return rn;
    endfunction

    // Percentile roll: the next number scaled onto 0..99.
    function automatic int unsigned roll_percent();
        int unsigned wide;
        wide = advance_shadow() * 32'd100;
        return wide >> 16;
    endfunction

    // Works out the result of one request and moves the shadow words on.
    function automatic t_rsp_beat predict_result(input t_req_beat r);
        t_rsp_beat           res;
        int unsigned         slot;
        int unsigned         warmup;
        int unsigned         roll_a;
        logic [PROD_W-1:0]   product;
        logic [SCALE_W-1:0]  scaled;
        res = '0;
        case (r.kind)
            REQ_RESEED: begin
                slot = r.seed % MOD_A;
                shadow_words[0] = RESEED_WORDS[slot];
                shadow_words[1] = RESEED_WORDS[(slot + 1) % 8];
                shadow_words[2] = RESEED_WORDS[(slot + 2) % 8];
                warmup = r.seed % MOD_B;
                repeat (warmup) void'(advance_shadow());
            end
            REQ_LOAD: begin
                shadow_words[0] = r.w0;
                shadow_words[1] = r.w1;
                shadow_words[2] = r.w2;
            end
            REQ_DRAW: begin
                product   = advance_shadow() * r.scale;
                scaled    = product[PROD_W-1:16];
                res.value = (scaled > 17'h0FFFF) ? 16'hFFFF : scaled[WORD_W-1:0];
            end
            REQ_ROLL: begin
                res.value = roll_percent();
                res.hit   = (r.thr > res.value);
            end
            REQ_ROLL2: begin
                roll_a    = roll_percent();
                res.value = (roll_a + roll_percent()) >> 1;
                res.hit   = (r.thr > res.value);
            end
            default: begin
            end
        endcase
        res.w0 = shadow_words[0];
        res.w1 = shadow_words[1];
        res.w2 = shadow_words[2];
        return res;
    endfunction

    // Offers one request beat and waits for it to be taken; the expectation is queued then.
    task automatic offer_request(input t_req_beat r, input logic typed, input t_rsp_beat want);
        t_rsp_beat predicted;
        while (idling_on && $urandom_range(0, 99) < IDLE_PCT) begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= r.kind;
        req_ch.seed       <= r.seed;
        req_ch.range_max  <= r.scale;
        req_ch.threshold  <= r.thr;
        req_ch.load_word0 <= r.w0;
        req_ch.load_word1 <= r.w1;
        req_ch.load_word2 <= r.w2;
        @(posedge clk);
        while (!req_ch.ready) @(posedge clk);
        predicted = predict_result(r);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Result side back-pressure.
    always @(posedge clk) begin
        rsp_ch.ready <= idling_on ? ($urandom_range(0, 99) >= IDLE_PCT) : 1'b1;
    end

    // Each result beat is compared with the oldest expectation.
    always @(posedge clk) begin
        t_rsp_beat got;
        t_rsp_beat want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            got = mk_rsp(rsp_ch.value, rsp_ch.hit, rsp_ch.state_word0, rsp_ch.state_word1,
                         rsp_ch.state_word2);
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result beat: value %h hit %b words %h %h %h",
                             got.value, got.hit, got.w0, got.w1, got.w2);
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("result mismatch (expected/actual): value %h/%h hit %b/%b",
                                 want.value, got.value, want.hit, got.hit);
                        $display("    words %h %h %h / %h %h %h",
                                 want.w0, want.w1, want.w2, got.w0, got.w1, got.w2);
                    end
                end
            end
        end
    end

    // Stimulus.
    initial begin
        t_req_beat r;
        int        pick;
        int        issued;
        int        n;
        rst_n             = 1'b0;
        idling_on         = 1'b1;
        mismatches        = 0;
        shadow_words[0]   = '0;
        shadow_words[1]   = '0;
        shadow_words[2]   = '0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_LOAD;
        req_ch.seed       = '0;
        req_ch.range_max  = '0;
        req_ch.threshold  = '0;
        req_ch.load_word0 = '0;
        req_ch.load_word1 = '0;
        req_ch.load_word2 = '0;

        // From reset the words are all zero, so early draws and rolls give zero.
        directed_rows.push_back('{mk_req(REQ_DRAW, 0, 17'h10000, 0, 0, 0, 0), 1'b1,
                                  mk_rsp(0, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_req(REQ_ROLL, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_rsp(0, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_req(REQ_ROLL2, 0, 0, 8'hFF, 0, 0, 0), 1'b1,
                                  mk_rsp(0, 1, 0, 0, 0)});
        directed_rows.push_back('{mk_req(REQ_ROLL, 0, 0, 1, 0, 0, 0), 1'b1,
                                  mk_rsp(0, 1, 0, 0, 0)});
        directed_rows.push_back('{mk_req(REQ_LOAD, 0, 0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF),
                                  1'b1, mk_rsp(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF)});
        // An undefined request type leaves the words as they stand.
        directed_rows.push_back('{mk_req(REQ_RSVD_A, 31'h7FFFFFFF, 17'h1FFFF, 8'hFF,
                                         16'hFFFF, 16'hFFFF, 16'hFFFF),
                                  1'b1, mk_rsp(0, 0, 16'hFFFF, 16'hFFFF, 16'hFFFF)});
        // Draws with oversized, zero and unit scales, then rolls.
        directed_rows.push_back('{mk_req(REQ_DRAW, 0, 17'h1FFFF, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_DRAW, 0, 17'h10001, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_DRAW, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_DRAW, 0, 1, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_ROLL, 0, 0, 8'hFF, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_ROLL2, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_ROLL, 0, 0, 50, 0, 0, 0), 1'b0, '0});
        // Reseeds: zero seed, largest seed, longest warm-up with the table wrap, no warm-up.
        directed_rows.push_back('{mk_req(REQ_RESEED, 0, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_RESEED, 31'h7FFFFFFF, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_RESEED, 160, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_RESEED, 161, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_RESEED, 22, 0, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_LOAD, 0, 0, 0, 16'hA5A5, 16'h5A5A, 16'h8000),
                                  1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_ROLL2, 0, 0, 100, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_RSVD_B, 12345, 17'h10000, 7, 1, 2, 3), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_RSVD_C, 99, 5, 9, 4, 5, 6), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_DRAW, 0, 17'h10000, 0, 0, 0, 0), 1'b0, '0});
        directed_rows.push_back('{mk_req(REQ_LOAD, 0, 0, 0, 0, 0, 0), 1'b1,
                                  mk_rsp(0, 0, 0, 0, 0)});
        directed_rows.push_back('{mk_req(REQ_DRAW, 0, 17'h1FFFF, 0, 0, 0, 0), 1'b1,
                                  mk_rsp(0, 0, 0, 0, 0)});

        // Synchronous reset.
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[i])
            offer_request(directed_rows[i].beat, directed_rows[i].typed, directed_rows[i].want);

        // Random requests, mostly draws and rolls with occasional reseeds, loads and noise.
        issued = 0;
        n = 0;
        while (issued < RANDOM_ITEMS) begin
            idling_on <= !(n >= 700 && n < 1000);
            pick = $urandom_range(0, 99);
            r = mk_req(REQ_DRAW, $urandom & 32'h7FFF_FFFF, $urandom_range(0, 131071),
                       $urandom_range(0, 255), $urandom, $urandom, $urandom);
            if (pick < 7) begin
                r.kind = REQ_RESEED;
                if ($urandom_range(0, 3) == 0)
                    r.seed = $urandom_range(0, 200);
            end else if (pick < 13) begin
                r.kind = REQ_LOAD;
            end else if (pick < 37) begin
                r.kind = REQ_DRAW;
            end else if (pick < 61) begin
                r.kind = REQ_ROLL;
            end else if (pick < 91) begin
                r.kind = REQ_ROLL2;
            end else begin
                case ($urandom_range(0, 2))
                    0: r.kind = REQ_RSVD_A;
                    1: r.kind = REQ_RSVD_B;
                    default: r.kind = REQ_RSVD_C;
                endcase
            end
            case ($urandom_range(0, 3))
                0: r.scale = 17'h10000;
                1: r.scale = $urandom_range(0, 255);
                2: r.scale = $urandom_range(65537, 131071);
                default: begin
                end
            endcase
            if ($urandom_range(0, 1) == 0)
                r.thr = $urandom_range(0, 110);
            offer_request(r, 1'b0, '0);
            if (r.kind <= REQ_ROLL2)
                issued++;
            n++;
        end
        req_ch.valid <= 1'b0;

        // Drain, then allow for a late stray beat.
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: files.f
+incdir+hw/rtl
hw/rtl/tsxr_pkg.sv
hw/rtl/tsxr_ifs.sv
hw/rtl/tsxr_datapath.sv
hw/rtl/tsxr_ctrl.sv
hw/rtl/three_word_shift_xor_rng.sv
hw/rtl/tsxr_checker.sv
test/three_word_shift_xor_rng_test.sv
